FILE: rtl/core/mlnp_pkg.sv
// shared types, codes and defaults for the mono last-note priority allocator
package mlnp_pkg;

    localparam int NOTE_W          = 7;
    localparam int ACTION_W        = 2;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NOTE_COUNT_DEF  = 128;

    typedef logic [NOTE_W-1:0]   note_t;
    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [1:0]          stack_op_t;

    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam action_t ACT_NONE     = 2'd0;
    localparam action_t ACT_GATE_ON  = 2'd1;
    localparam action_t ACT_PITCH    = 2'd2;
    localparam action_t ACT_GATE_OFF = 2'd3;

    localparam stack_op_t OP_HOLD = 2'd0;
    localparam stack_op_t OP_PUSH = 2'd1;
    localparam stack_op_t OP_POP  = 2'd2;

endpackage

FILE: rtl/core/mlnp_if.sv
// valid/ready channel interfaces for note events and voice results
interface mlnp_evt_if;
    import mlnp_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    note_t note;

    modport source (output valid, output kind, output note, input ready);
    modport sink (input valid, input kind, input note, output ready);
endinterface

interface mlnp_res_if;
    import mlnp_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    note_t   note_out;
    logic    overflow;

    modport source (output valid, output action, output note_out, output overflow,
                    input ready);
    modport sink (input valid, input action, input note_out, input overflow,
                  output ready);
endinterface

FILE: rtl/core/mlnp_cell.sv
// one note stack cell, shifting toward the bottom on push and toward the top on pop
module mlnp_cell (
    input  logic               clk,
    input  mlnp_pkg::stack_op_t op,
    input  mlnp_pkg::note_t    above,
    input  mlnp_pkg::note_t    below,
    output mlnp_pkg::note_t    value
);
    import mlnp_pkg::*;

    note_t value_reg;
    note_t value_next;

    always_comb
    begin
        case (op)
            OP_PUSH: value_next = above;
            OP_POP:  value_next = below;
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/core/mono_last_note_priority.sv
// mono last-note priority voice allocator, top level
// evt (sink) carries one note transaction: kind 0 press, kind 1 release, and note.
// res (source) returns exactly one transaction per event: action, note_out, overflow.
// a press, an ignored note and a release of a note that is not sounding give their
// result in the cycle after acceptance.
// a release of the sounding note walks the note stack one cell per cycle from the top,
// popping notes no longer held until a held note or an empty stack ends the walk.
// one event is in flight at a time; evt.ready is high when no release is walking the
// stack and the result register is empty or being taken in the same cycle.
// a stalled res simply holds its result and blocks further events until it is taken.
// reset clears the held-note map, the stack count and the sounding note at once;
// the stack cells themselves are not cleared and are only read below the count.
module mono_last_note_priority #(
    parameter int STACK_DEPTH = mlnp_pkg::STACK_DEPTH_DEF,
    parameter int NOTE_COUNT  = mlnp_pkg::NOTE_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mlnp_evt_if.sink   evt,
    mlnp_res_if.source res
);
    import mlnp_pkg::*;

    localparam int NOTE_IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam logic [NOTE_W:0] NOTE_LIMIT = (NOTE_W + 1)'(NOTE_COUNT);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    note_t                 sounding_reg;
    note_t                 sounding_next;
    logic [NOTE_COUNT-1:0] held_reg;
    logic [NOTE_COUNT-1:0] held_next;

    logic    res_valid_reg;
    logic    res_valid_next;
    action_t action_reg;
    action_t action_next;
    note_t   note_out_reg;
    note_t   note_out_next;
    logic    overflow_reg;
    logic    overflow_next;

    stack_op_t op;
    note_t     cell_value [STACK_DEPTH];
    note_t     cell_above [STACK_DEPTH];
    note_t     cell_below [STACK_DEPTH];

    logic                  evt_fire;
    logic                  note_ok;
    logic [NOTE_IDX_W-1:0] note_idx;
    logic                  full;
    logic                  empty;
    note_t                 top_note;
    logic                  top_ok;
    logic                  top_held;

    // stack cell chain, top of stack in cell 0
    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_top
                assign cell_above[i] = evt.note;
            end
            else
            begin : g_mid_above
                assign cell_above[i] = cell_value[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_bottom
                assign cell_below[i] = '0;
            end
            else
            begin : g_mid_below
                assign cell_below[i] = cell_value[i+1];
            end
            mlnp_cell u_cell (
                .clk   (clk),
                .op    (op),
                .above (cell_above[i]),
                .below (cell_below[i]),
                .value (cell_value[i])
            );
        end
    endgenerate

    assign evt_fire  = evt.valid && evt.ready;
    assign note_ok   = {1'b0, evt.note} < NOTE_LIMIT;
    assign note_idx  = evt.note[NOTE_IDX_W-1:0];
    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign top_note  = cell_value[0];
    assign top_ok    = {1'b0, top_note} < NOTE_LIMIT;
    assign top_held  = held_reg[top_note[NOTE_IDX_W-1:0]];

    assign evt.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sounding_next  = sounding_reg;
        held_next      = held_reg;
        op             = OP_HOLD;
        res_valid_next = res_valid_reg && !res.ready;
        action_next    = action_reg;
        note_out_next  = note_out_reg;
        overflow_next  = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_fire)
                begin
                    if (!note_ok)
                    begin
                        res_valid_next = 1'b1;
                        action_next    = ACT_NONE;
                        note_out_next  = sounding_reg;
                        overflow_next  = 1'b0;
                    end
                    else if (evt.kind == KIND_PRESS)
                    begin
                        held_next[note_idx] = 1'b1;
                        sounding_next       = evt.note;
                        if (!full)
                        begin
                            op         = OP_PUSH;
                            count_next = count_reg + CNT_W'(1);
                        end
                        res_valid_next = 1'b1;
                        action_next    = ACT_GATE_ON;
                        note_out_next  = evt.note;
                        overflow_next  = full;
                    end
                    else
                    begin
                        held_next[note_idx] = 1'b0;
                        if (evt.note != sounding_reg)
                        begin
                            res_valid_next = 1'b1;
                            action_next    = ACT_NONE;
                            note_out_next  = sounding_reg;
                            overflow_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (empty)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    action_next    = ACT_GATE_OFF;
                    note_out_next  = sounding_reg;
                    overflow_next  = 1'b0;
                end
                else if (top_ok && top_held)
                begin
                    state_next     = ST_IDLE;
                    sounding_next  = top_note;
                    res_valid_next = 1'b1;
                    action_next    = ACT_PITCH;
                    note_out_next  = top_note;
                    overflow_next  = 1'b0;
                end
                else
                begin
                    op         = OP_POP;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sounding_reg  <= '0;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sounding_reg  <= sounding_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        note_out_reg <= note_out_next;
        overflow_reg <= overflow_next;
    end

    assign res.valid    = res_valid_reg;
    assign res.action   = action_reg;
    assign res.note_out = note_out_reg;
    assign res.overflow = overflow_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stack count beyond depth");

    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=>
            (state_reg == ST_IDLE) || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("stack walk did not pop one cell");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.overflow) |-> full)
        else $error("overflow reported with room on the stack");

    a_gate_off_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.action == ACT_GATE_OFF)) |-> empty)
        else $error("gate off with notes left on the stack");

    a_no_result_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> !res_valid_reg)
        else $error("result pending during stack walk");
`endif

endmodule
